// ===== rtl/bgr24_to_rgb5a3_colorkey_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the color-key converter RTL.
// ---------------------------------------------------------------------------
`ifndef BGR24_TO_RGB5A3_COLORKEY_MACROS_SVH
`define BGR24_TO_RGB5A3_COLORKEY_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define BGRCK_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define BGRCK_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bgrck_pkg.sv =====
// ---------------------------------------------------------------------------
// bgrck_pkg
// Types and constants shared by the BGR24 to RGB5A3 color-key converter.
// ---------------------------------------------------------------------------
package bgrck_pkg;

  localparam int MAX_SIDE_DEF    = 1024;
  localparam int MIN_SIDE        = 8;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int SIDE_CFG_W  = 11;
  localparam int CHAN_W      = 8;
  localparam int INDEX_W     = 20;
  localparam int WORD_W      = 16;
  localparam int APB_ADDR_W  = 5;
  localparam int APB_DATA_W  = 32;

  localparam logic [SIDE_CFG_W-1:0] SIDE_RESET = SIDE_CFG_W'(8);

  typedef enum logic [2:0] {
    REG_WIDTH     = 3'd0,
    REG_HEIGHT    = 3'd1,
    REG_KEY_RED   = 3'd2,
    REG_KEY_GREEN = 3'd3,
    REG_KEY_BLUE  = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_BLUE  = 2'd0,
    PH_GREEN = 2'd1,
    PH_RED   = 2'd2
  } phase_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [SIDE_CFG_W-1:0] image_width;
    logic [SIDE_CFG_W-1:0] image_height;
    logic [CHAN_W-1:0]     key_red;
    logic [CHAN_W-1:0]     key_green;
    logic [CHAN_W-1:0]     key_blue;
  } cfg_t;

endpackage

// ===== rtl/bgrck_byte_if.sv =====
// ---------------------------------------------------------------------------
// bgrck_byte_if
// Valid/ready channel carrying one bitmap byte per item.
// ---------------------------------------------------------------------------
interface bgrck_byte_if;
  import bgrck_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] byte_value;

  modport source (output valid, output byte_value, input ready);
  modport sink (input valid, input byte_value, output ready);
endinterface

// ===== rtl/bgrck_rgb_if.sv =====
// ---------------------------------------------------------------------------
// bgrck_rgb_if
// Valid/ready channel carrying one assembled BGR pixel per item.
// ---------------------------------------------------------------------------
interface bgrck_rgb_if;
  import bgrck_pkg::*;

  logic   valid;
  logic   ready;
  pixel_t pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

// ===== rtl/bgrck_texel_if.sv =====
// ---------------------------------------------------------------------------
// bgrck_texel_if
// Valid/ready channel carrying one RGB5A3 texel and its index per item.
// ---------------------------------------------------------------------------
interface bgrck_texel_if;
  import bgrck_pkg::*;

  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] pixel_index;
  logic [WORD_W-1:0]  pixel_word;
  logic               last_pixel;

  modport source (output valid, output pixel_index, output pixel_word,
                  output last_pixel, input ready);
  modport sink (input valid, input pixel_index, input pixel_word,
                input last_pixel, output ready);
endinterface

// ===== rtl/bgrck_queue.sv =====
// ---------------------------------------------------------------------------
// bgrck_queue
// Small pixel queue between the byte assembler and the packer.
// ---------------------------------------------------------------------------
`include "bgr24_to_rgb5a3_colorkey_macros.svh"

module bgrck_queue #(
  parameter int DEPTH = bgrck_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  bgrck_rgb_if.sink   wr,
  bgrck_rgb_if.source rd
);
  import bgrck_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  pixel_t           entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign wr.ready = (count != CNT_W'(DEPTH));
  assign rd.valid = (count != '0);
  assign rd.pixel = entries[rd_ptr];
  assign push     = wr.valid && wr.ready;
  assign pop      = rd.valid && rd.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr.pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `BGRCK_ASSERT_IMP(a_count_bound, 1'b1, count <= CNT_W'(DEPTH), "queue count above depth")
  `BGRCK_ASSERT_NXT(a_count_up, push && !pop, count == $past(count) + 1'b1, "queue fill lost")
  `BGRCK_ASSERT_NXT(a_count_dn, pop && !push, count == $past(count) - 1'b1, "queue drain lost")

endmodule

// ===== rtl/bgrck_front.sv =====
// ---------------------------------------------------------------------------
// bgrck_front
// Collects blue, green and red bytes and pushes each finished pixel.
// ---------------------------------------------------------------------------
module bgrck_front (
  input  logic         clk,
  input  logic         rst,
  bgrck_byte_if.sink   bytes,
  bgrck_rgb_if.source  pix
);
  import bgrck_pkg::*;

  phase_t            phase;
  phase_t            phase_next;
  logic [CHAN_W-1:0] blue_hold;
  logic [CHAN_W-1:0] green_hold;
  logic              take;

  assign take = bytes.valid && bytes.ready;

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_BLUE: begin
        if (take) phase_next = PH_GREEN;
      end
      PH_GREEN: begin
        if (take) phase_next = PH_RED;
      end
      PH_RED: begin
        if (take) phase_next = PH_BLUE;
      end
      default: phase_next = PH_BLUE;
    endcase
  end

  // A red byte completes a pixel, so it is taken only when the queue has room.
  always_comb begin
    bytes.ready = 1'b1;
    pix.valid   = 1'b0;
    unique case (phase) inside
      PH_BLUE, PH_GREEN: begin
        bytes.ready = 1'b1;
      end
      PH_RED: begin
        bytes.ready = pix.ready;
        pix.valid   = bytes.valid;
      end
      default: begin
        bytes.ready = 1'b1;
      end
    endcase
  end

  assign pix.pixel = '{red: bytes.byte_value, green: green_hold, blue: blue_hold};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_BLUE;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blue_hold  <= '0;
      green_hold <= '0;
    end else if (take) begin
      if (phase == PH_BLUE) blue_hold <= bytes.byte_value;
      if (phase == PH_GREEN) green_hold <= bytes.byte_value;
    end
  end

endmodule

// ===== rtl/bgrck_back.sv =====
// ---------------------------------------------------------------------------
// bgrck_back
// Packs queued pixels into RGB5A3, tracks row and column, registers output.
// ---------------------------------------------------------------------------
`include "bgr24_to_rgb5a3_colorkey_macros.svh"

module bgrck_back #(
  parameter int MAX_SIDE = bgrck_pkg::MAX_SIDE_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  bgrck_pkg::cfg_t     cfg,
  bgrck_rgb_if.sink           pix,
  bgrck_texel_if.source       texels
);
  import bgrck_pkg::*;

  localparam int SW = $clog2(MAX_SIDE + 1);
  localparam int CW = $clog2(MAX_SIDE);
  localparam int PW = SW + CW + 1;
  localparam int IW = (PW > INDEX_W) ? PW : INDEX_W;

  logic [SW-1:0]      w_sat;
  logic [SW-1:0]      h_sat;
  logic [CW-1:0]      row_count;
  logic [CW-1:0]      column_count;
  logic               image_start;
  logic [CW-1:0]      row_cur;
  logic [CW-1:0]      col_cur;
  logic [CW:0]        col_inc;
  logic               wrap;
  logic               last_next;
  logic               key_hit;
  logic [WORD_W-1:0]  word_next;
  logic [IW-1:0]      index_wide;
  logic               pop;
  logic               out_valid;
  logic [INDEX_W-1:0] out_index;
  logic [WORD_W-1:0]  out_word;
  logic               out_last;

  // Sizes outside the supported range are saturated before use.
  always_comb begin
    if (int'(cfg.image_width) < MIN_SIDE) begin
      w_sat = SW'(MIN_SIDE);
    end else if (int'(cfg.image_width) > MAX_SIDE) begin
      w_sat = SW'(MAX_SIDE);
    end else begin
      w_sat = SW'(cfg.image_width);
    end
    if (int'(cfg.image_height) < MIN_SIDE) begin
      h_sat = SW'(MIN_SIDE);
    end else if (int'(cfg.image_height) > MAX_SIDE) begin
      h_sat = SW'(MAX_SIDE);
    end else begin
      h_sat = SW'(cfg.image_height);
    end
  end

  // The first pixel of an image lands in the top row, column zero.
  assign row_cur   = image_start ? CW'(h_sat - 1'b1) : row_count;
  assign col_cur   = image_start ? '0 : column_count;
  assign col_inc   = {1'b0, col_cur} + 1'b1;
  assign wrap      = ((SW + 1)'(col_inc) >= (SW + 1)'(w_sat));
  assign last_next = wrap && (row_cur == '0);

  assign key_hit = (pix.pixel.red == cfg.key_red) && (pix.pixel.green == cfg.key_green)
                   && (pix.pixel.blue == cfg.key_blue);

  always_comb begin
    if (key_hit) begin
      word_next = {4'b0000, pix.pixel.red[7:4], pix.pixel.green[7:4], pix.pixel.blue[7:4]};
    end else begin
      word_next = {1'b1, pix.pixel.red[7:3], pix.pixel.green[7:3], pix.pixel.blue[7:3]};
    end
  end

  assign index_wide = IW'(w_sat) * IW'(row_cur) + IW'(col_cur);

  assign pop       = pix.valid && (!out_valid || texels.ready);
  assign pix.ready = !out_valid || texels.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_start  <= 1'b1;
      row_count    <= '0;
      column_count <= '0;
    end else if (pop) begin
      if (wrap) begin
        column_count <= '0;
        if (row_cur == '0) begin
          image_start <= 1'b1;
        end else begin
          image_start <= 1'b0;
          row_count   <= row_cur - 1'b1;
        end
      end else begin
        image_start  <= 1'b0;
        column_count <= col_inc[CW-1:0];
        row_count    <= row_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (texels.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_index <= index_wide[INDEX_W-1:0];
      out_word  <= word_next;
      out_last  <= last_next;
    end
  end

  assign texels.valid       = out_valid;
  assign texels.pixel_index = out_index;
  assign texels.pixel_word  = out_word;
  assign texels.last_pixel  = out_last;

  `BGRCK_ASSERT_NXT(a_pop_fills, pop, out_valid, "popped pixel not registered")
  `BGRCK_ASSERT_IMP(a_last_restart, out_valid && out_last, image_start, "no restart after last pixel")
  `BGRCK_ASSERT_IMP(a_last_column, out_valid && out_last, column_count == '0, "column not cleared at last pixel")

endmodule

// ===== rtl/bgr24_to_rgb5a3_colorkey.sv =====
// ---------------------------------------------------------------------------
// bgr24_to_rgb5a3_colorkey
// Converts a 24-bit bottom-up bitmap byte stream into RGB5A3 texels.
// ---------------------------------------------------------------------------
// The block takes one bitmap byte per clock cycle in blue, green, red order,
// except while a red byte waits for room in the queue, and delivers one texel
// for every third byte, with no bubbles on the byte side for a continuous
// stream while the queue has room. A byte goes into the assembler, the
// finished pixel waits in a small queue, and the packer multiplies width by
// row and registers the texel. The queue and the output register let the byte
// side keep flowing while the texel side stalls, until the queue fills. Image
// size and key color are set over the APB port and must only be written while
// no pixel is in flight.
module bgr24_to_rgb5a3_colorkey #(
  parameter int MAX_SIDE    = bgrck_pkg::MAX_SIDE_DEF,
  parameter int QUEUE_DEPTH = bgrck_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bgrck_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [bgrck_pkg::APB_DATA_W-1:0] pwdata,
  output logic [bgrck_pkg::APB_DATA_W-1:0] prdata,
  output logic                             pready,
  bgrck_byte_if.sink                       bytes,
  bgrck_texel_if.source                    texels
);
  import bgrck_pkg::*;

  cfg_t     cfg;
  reg_idx_t reg_sel;
  logic     cfg_write;

  bgrck_rgb_if q_in ();
  bgrck_rgb_if q_out ();

  assign pready    = 1'b1;
  assign reg_sel   = reg_idx_t'(paddr[4:2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= SIDE_RESET;
      cfg.image_height <= SIDE_RESET;
      cfg.key_red      <= '0;
      cfg.key_green    <= '0;
      cfg.key_blue     <= '0;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_WIDTH:     cfg.image_width  <= pwdata[SIDE_CFG_W-1:0];
        REG_HEIGHT:    cfg.image_height <= pwdata[SIDE_CFG_W-1:0];
        REG_KEY_RED:   cfg.key_red      <= pwdata[CHAN_W-1:0];
        REG_KEY_GREEN: cfg.key_green    <= pwdata[CHAN_W-1:0];
        REG_KEY_BLUE:  cfg.key_blue     <= pwdata[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_WIDTH:     prdata = APB_DATA_W'(cfg.image_width);
      REG_HEIGHT:    prdata = APB_DATA_W'(cfg.image_height);
      REG_KEY_RED:   prdata = APB_DATA_W'(cfg.key_red);
      REG_KEY_GREEN: prdata = APB_DATA_W'(cfg.key_green);
      REG_KEY_BLUE:  prdata = APB_DATA_W'(cfg.key_blue);
      default:       prdata = '0;
    endcase
  end

  bgrck_front u_front (
    .clk   (clk),
    .rst   (rst),
    .bytes (bytes),
    .pix   (q_in)
  );

  bgrck_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk (clk),
    .rst (rst),
    .wr  (q_in),
    .rd  (q_out)
  );

  bgrck_back #(
    .MAX_SIDE (MAX_SIDE)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .pix    (q_out),
    .texels (texels)
  );

endmodule

// ===== tb/bgr24_to_rgb5a3_colorkey_checker.sv =====
// ---------------------------------------------------------------------------
// bgr24_to_rgb5a3_colorkey_checker
// Watches the register port and both streams of the color-key converter,
// predicts every texel from the accepted bitmap bytes and compares each
// delivered texel field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module bgr24_to_rgb5a3_colorkey_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic                             pready,
  input  logic [bgrck_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [bgrck_pkg::APB_DATA_W-1:0] pwdata,
  bgrck_byte_if                            byte_mon,
  bgrck_texel_if                           texel_mon,
  output int unsigned                      mismatch_count,
  output int unsigned                      texels_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import bgrck_pkg::*;

  typedef struct packed {
    logic [INDEX_W-1:0] pixel_index;
    logic [WORD_W-1:0]  pixel_word;
    logic               last_pixel;
  } texel_t;

  texel_t      expected_texels[$];
  int unsigned fail_tally = 0;

  // Register copy and the conversion state of the predictor.
  cfg_t        cfg;
  phase_t      byte_phase;
  logic [7:0]  blue_hold;
  logic [7:0]  green_hold;
  int unsigned column_count;
  int unsigned row_count;
  bit          image_start;

  function automatic int unsigned clamp_side(input logic [SIDE_CFG_W-1:0] side);
    if (side < MIN_SIDE) return MIN_SIDE;
    if (side > MAX_SIDE_DEF) return MAX_SIDE_DEF;
    return side;
  endfunction

  function automatic logic [WORD_W-1:0] rgb5a3(input logic [7:0] r, g, b);
    if (r == cfg.key_red && g == cfg.key_green && b == cfg.key_blue)
      return {4'b0000, r[7:4], g[7:4], b[7:4]};
    return {1'b1, r[7:3], g[7:3], b[7:3]};
  endfunction

  function automatic void clear_state();
    cfg.image_width = SIDE_RESET;
    cfg.image_height = SIDE_RESET;
    cfg.key_red = '0;
    cfg.key_green = '0;
    cfg.key_blue = '0;
    byte_phase = PH_BLUE;
    blue_hold = '0;
    green_hold = '0;
    column_count = 0;
    row_count = MIN_SIDE - 1;
    image_start = 1'b1;
    expected_texels.delete();
  endfunction

  function automatic void take_register(input logic [APB_ADDR_W-1:0] addr,
                                        input logic [APB_DATA_W-1:0] data);
    case (reg_idx_t'(addr[APB_ADDR_W-1:2]))
      REG_WIDTH:     cfg.image_width = data[SIDE_CFG_W-1:0];
      REG_HEIGHT:    cfg.image_height = data[SIDE_CFG_W-1:0];
      REG_KEY_RED:   cfg.key_red = data[CHAN_W-1:0];
      REG_KEY_GREEN: cfg.key_green = data[CHAN_W-1:0];
      REG_KEY_BLUE:  cfg.key_blue = data[CHAN_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void absorb_byte(input logic [7:0] value);
    int unsigned width;
    texel_t      texel;
    case (byte_phase)
      PH_BLUE: begin
        blue_hold = value;
        byte_phase = PH_GREEN;
      end
      PH_GREEN: begin
        green_hold = value;
        byte_phase = PH_RED;
      end
      default: begin
        byte_phase = PH_BLUE;
        width = clamp_side(cfg.image_width);
        // The height is only looked at when a new image begins.
        if (image_start) begin
          row_count = clamp_side(cfg.image_height) - 1;
          column_count = 0;
          image_start = 1'b0;
        end
        texel.pixel_index = INDEX_W'(width * row_count + column_count);
        texel.pixel_word = rgb5a3(value, green_hold, blue_hold);
        texel.last_pixel = 1'b0;
        if (column_count + 1 >= width) begin
          column_count = 0;
          if (row_count == 0) begin
            texel.last_pixel = 1'b1;
            image_start = 1'b1;
          end else begin
            row_count = row_count - 1;
          end
        end else begin
          column_count = column_count + 1;
        end
        expected_texels.push_back(texel);
      end
    endcase
  endfunction

  function automatic void check_texel();
    texel_t want;
    if (expected_texels.size() == 0) begin
      $error("texel with no pixel pending: pixel_index %0d pixel_word %h last_pixel %0b",
             texel_mon.pixel_index, texel_mon.pixel_word, texel_mon.last_pixel);
      fail_tally++;
      return;
    end
    want = expected_texels.pop_front();
    if (texel_mon.pixel_index !== want.pixel_index) begin
      $error("pixel_index: expected %0d, actual %0d", want.pixel_index,
             texel_mon.pixel_index);
      fail_tally++;
    end
    if (texel_mon.pixel_word !== want.pixel_word) begin
      $error("pixel_word: expected %h, actual %h", want.pixel_word, texel_mon.pixel_word);
      fail_tally++;
    end
    if (texel_mon.last_pixel !== want.last_pixel) begin
      $error("last_pixel: expected %0b, actual %0b", want.last_pixel,
             texel_mon.last_pixel);
      fail_tally++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
    end else begin
      if (psel && penable && pwrite && pready) take_register(paddr, pwdata);
      if (texel_mon.valid && texel_mon.ready) check_texel();
      if (byte_mon.valid && byte_mon.ready) absorb_byte(byte_mon.byte_value);
    end
    mismatch_count <= fail_tally;
    texels_pending <= expected_texels.size();
  end

endmodule

// ===== tb/bgr24_to_rgb5a3_colorkey_test.sv =====
// ---------------------------------------------------------------------------
// bgr24_to_rgb5a3_colorkey_test
// Drives bitmap bytes and register writes into the color-key converter under
// several flow-control regimes; a checker beside the block predicts and
// compares every texel, and this module reports the verdict.
// ---------------------------------------------------------------------------
module bgr24_to_rgb5a3_colorkey_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bgrck_pkg::*;

  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  // Opening pixels in blue, green, red order: key black, white, a one-bit
  // miss in each channel, and alternating bit patterns.
  localparam logic [7:0] OPENING_BYTES [21] = '{
    8'h00, 8'h00, 8'h00,
    8'hFF, 8'hFF, 8'hFF,
    8'h01, 8'h00, 8'h00,
    8'h00, 8'h01, 8'h00,
    8'h00, 8'h00, 8'h01,
    8'hAA, 8'h55, 8'hAA,
    8'h55, 8'hAA, 8'h55
  };

  typedef enum logic [1:0] {
    FLOW_FREE,
    FLOW_SENDER_IDLE,
    FLOW_SINK_STALL,
    FLOW_BOTH
  } flow_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int unsigned mismatch_count;
  int unsigned texels_pending;
  int unsigned lasts_seen = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  bit          long_hold_req = 1'b0;

  // Stimulus side: position within the current pixel and the pixel itself.
  int unsigned byte_slot = 0;
  logic [7:0]  pix [3];
  logic [7:0]  key_bgr [3];

  bgrck_byte_if  byte_ch ();
  bgrck_texel_if texel_ch ();

  bgr24_to_rgb5a3_colorkey uut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .bytes   (byte_ch.sink),
    .texels  (texel_ch.source)
  );

  bgr24_to_rgb5a3_colorkey_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .byte_mon       (byte_ch),
    .texel_mon      (texel_ch),
    .mismatch_count (mismatch_count),
    .texels_pending (texels_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && texel_ch.valid && texel_ch.ready && texel_ch.last_pixel)
      lasts_seen <= lasts_seen + 1;
  end

  always @(posedge clk) begin
    if ((byte_ch.valid && byte_ch.ready) || (texel_ch.valid && texel_ch.ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Texel receiver: random stalls, plus a long hold-off on request.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    texel_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        texel_ch.ready <= 1'b0;
      end else begin
        texel_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  task automatic set_flow(input flow_t flow);
    case (flow)
      FLOW_FREE: begin
        send_idle_pct = 0;
        sink_stall_pct = 0;
      end
      FLOW_SENDER_IDLE: begin
        send_idle_pct = 82;
        sink_stall_pct = 0;
      end
      FLOW_SINK_STALL: begin
        send_idle_pct = 0;
        sink_stall_pct = 82;
      end
      default: begin
        send_idle_pct = 26;
        sink_stall_pct = 26;
      end
    endcase
  endtask

  task automatic send_byte(input logic [7:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.byte_value <= value;
    do @(posedge clk); while (!byte_ch.ready);
    byte_slot = (byte_slot + 1) % 3;
  endtask

  // Picks a new pixel at the start of each triple: mostly random, often the
  // key color, sometimes the key color with a single bit flipped.
  task automatic send_image_byte();
    int unsigned pick;
    int unsigned chan;
    int unsigned bit_pos;
    if (byte_slot == 0) begin
      pick = $urandom_range(99);
      for (int c = 0; c < 3; c++) pix[c] = (pick < 45) ? key_bgr[c] : 8'($urandom_range(255));
      if (pick >= 30 && pick < 45) begin
        chan = $urandom_range(2);
        bit_pos = $urandom_range(7);
        pix[chan][bit_pos] = ~pix[chan][bit_pos];
      end
    end
    send_byte(pix[byte_slot]);
  endtask

  task automatic wait_empty();
    byte_ch.valid <= 1'b0;
    do @(posedge clk); while (texels_pending != 0);
  endtask

  // A partial pixel produces no texel, so give the pipeline time to go quiet.
  task automatic settle();
    wait_empty();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic configure(input logic [SIDE_CFG_W-1:0] w, h,
                           input logic [7:0] kr, kg, kb);
    write_reg(REG_WIDTH, APB_DATA_W'(w));
    write_reg(REG_HEIGHT, APB_DATA_W'(h));
    write_reg(REG_KEY_RED, APB_DATA_W'(kr));
    write_reg(REG_KEY_GREEN, APB_DATA_W'(kg));
    write_reg(REG_KEY_BLUE, APB_DATA_W'(kb));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    key_bgr[0] = kb;
    key_bgr[1] = kg;
    key_bgr[2] = kr;
  endtask

  // Narrows the rows and streams pixels one at a time until the current
  // image closes, so that the next height written takes effect.
  task automatic finish_image();
    int unsigned seen;
    seen = lasts_seen;
    settle();
    configure(SIDE_CFG_W'(8), SIDE_CFG_W'(8), key_bgr[2], key_bgr[1], key_bgr[0]);
    while (lasts_seen == seen) begin
      send_image_byte();
      if (byte_slot == 0) wait_empty();
    end
  endtask

  task automatic run_phase(input logic [SIDE_CFG_W-1:0] w, h,
                           input logic [7:0] kr, kg, kb,
                           input flow_t flow, input int unsigned count,
                           input bit fresh_image, input bit hold_mid,
                           input bit pause_mid);
    if (fresh_image) finish_image();
    settle();
    configure(w, h, kr, kg, kb);
    set_flow(flow);
    for (int unsigned i = 0; i < count; i++) begin
      if (i == count / 2 && hold_mid) long_hold_req = 1'b1;
      if (i == count / 2 && pause_mid) wait_empty();
      send_image_byte();
    end
  endtask

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    byte_ch.valid <= 1'b0;
    byte_ch.byte_value <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    settle();
    configure(SIDE_CFG_W'(8), SIDE_CFG_W'(8), 8'h00, 8'h00, 8'h00);
    set_flow(FLOW_FREE);
    foreach (OPENING_BYTES[i]) send_byte(OPENING_BYTES[i]);
    settle();
    configure(SIDE_CFG_W'(8), SIDE_CFG_W'(8), 8'h12, 8'h34, 8'h56);
    send_byte(8'h56);
    send_byte(8'h34);
    send_byte(8'h12);

    run_phase(11'd8, 11'd8, 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)), FLOW_FREE, 150, 1'b0, 1'b1, 1'b0);
    // Sizes below the minimum are raised to it.
    run_phase(11'd0, 11'd0, 8'h00, 8'h00, 8'h00, FLOW_SENDER_IDLE, 150, 1'b1, 1'b0, 1'b0);
    run_phase(11'd16, 11'd8, 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)), FLOW_SINK_STALL, 150, 1'b0, 1'b0, 1'b0);
    run_phase(11'd9, 11'd3, 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)), FLOW_BOTH, 150, 1'b1, 1'b0, 1'b0);
    run_phase(11'd13, 11'd8, 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)), FLOW_FREE, 100, 1'b0, 1'b0, 1'b1);
    run_phase(11'd8, 11'd16, 8'hFF, 8'hFF, 8'hFF, FLOW_SENDER_IDLE, 100, 1'b1, 1'b0, 1'b0);
    run_phase(11'd24, 11'd8, 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)), FLOW_SINK_STALL, 100, 1'b0, 1'b0, 1'b0);
    run_phase(11'd2047, 11'd8, 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)), FLOW_BOTH, 100, 1'b0, 1'b0, 1'b0);
    // Full-size image starting at the top row reaches the highest indexes.
    run_phase(11'd1024, 11'd2047, 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)), FLOW_FREE, 100, 1'b1, 1'b0, 1'b0);
    run_phase(11'd2047, 11'd1024, 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)), FLOW_SINK_STALL, 100, 1'b0, 1'b0, 1'b0);

    settle();
    if (mismatch_count == 0 && texels_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
